@@ src/mbad_pkg.sv @@
// Shared types, address map constants and the device lookup for the memory bus decoder.
// No dependencies; used by every module of the block.
package mbad_pkg;

  localparam int unsigned WORK_RAM_BYTES = 8192;
  localparam int unsigned HIGH_RAM_BYTES = 127;
  localparam int unsigned WRAM_AW        = $clog2(WORK_RAM_BYTES);
  localparam int unsigned HRAM_AW        = $clog2(HIGH_RAM_BYTES);

  localparam logic [15:0] ADDR_BOOT_END  = 16'h0100;
  localparam logic [15:0] ADDR_VRAM      = 16'h8000;
  localparam logic [15:0] ADDR_XRAM      = 16'hA000;
  localparam logic [15:0] ADDR_WRAM      = 16'hC000;
  localparam logic [15:0] ADDR_OAM       = 16'hFE00;
  localparam logic [15:0] ADDR_OAM_END   = 16'hFEA0;
  localparam logic [15:0] ADDR_JOYP      = 16'hFF00;
  localparam logic [15:0] ADDR_IO_VIDEO  = 16'hFF03;
  localparam logic [15:0] ADDR_TIMER     = 16'hFF04;
  localparam logic [15:0] ADDR_TIMER_END = 16'hFF08;
  localparam logic [15:0] ADDR_IF        = 16'hFF0F;
  localparam logic [15:0] ADDR_SOUND     = 16'hFF10;
  localparam logic [15:0] ADDR_SOUND_END = 16'hFF40;
  localparam logic [15:0] ADDR_LCD_END   = 16'hFF4C;
  localparam logic [15:0] ADDR_DMA       = 16'hFF46;
  localparam logic [15:0] ADDR_BOOT_OFF  = 16'hFF50;
  localparam logic [15:0] ADDR_HRAM      = 16'hFF80;
  localparam logic [15:0] ADDR_IE        = 16'hFFFF;

  localparam logic [7:0] BYTE_OPEN   = 8'hFF;
  localparam logic [7:0] IF_FILL     = 8'hE0;
  localparam logic [7:0] JOYP_FILL   = 8'hC0;
  localparam logic [7:0] DMA_LIMIT   = 8'hE0;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [2:0] {
    TGT_NONE  = 3'd0,
    TGT_CART  = 3'd1,
    TGT_VIDEO = 3'd2,
    TGT_SOUND = 3'd3,
    TGT_TIMER = 3'd4,
    TGT_VT    = 3'd5
  } tgt_e;

  typedef struct packed {
    logic       action;
    logic [15:0] addr;
    logic [7:0] wdata;
    logic [7:0] keys;
    logic [7:0] cart_rdata;
    logic [7:0] ppu_rdata;
    logic [7:0] apu_rdata;
    logic [7:0] timer_rdata;
    logic [7:0] boot_rdata;
  } req_t;

  typedef struct packed {
    logic [7:0] wram_rdata;
    logic [7:0] hram_rdata;
    logic [1:0] pad_select;
    logic [4:0] int_enable;
    logic       boot_mapped;
  } state_rd_t;

  typedef struct packed {
    logic [7:0] rdata;
    tgt_e       target;
    logic       forward_write;
    logic       dma_start;
    logic [7:0] dma_page;
  } result_t;

  function automatic tgt_e device_of(logic [15:0] a);
    tgt_e t;
    if (a < ADDR_VRAM) begin
      t = TGT_CART;
    end else if (a < ADDR_XRAM) begin
      t = TGT_VIDEO;
    end else if (a < ADDR_WRAM) begin
      t = TGT_CART;
    end else if (a < ADDR_OAM) begin
      t = TGT_NONE;
    end else if (a < ADDR_OAM_END) begin
      t = TGT_VIDEO;
    end else if (a < ADDR_IO_VIDEO) begin
      t = TGT_NONE;
    end else if (a >= ADDR_TIMER && a < ADDR_TIMER_END) begin
      t = TGT_TIMER;
    end else if (a == ADDR_IF) begin
      t = TGT_VT;
    end else if (a >= ADDR_SOUND && a < ADDR_SOUND_END) begin
      t = TGT_SOUND;
    end else if (a < ADDR_LCD_END) begin
      t = TGT_VIDEO;
    end else begin
      t = TGT_NONE;
    end
    return t;
  endfunction

endpackage

@@ src/mbad_state.sv @@
// Internal storage of the decoder: work RAM, high RAM, joypad select, interrupt enable
// and the boot overlay flag. Updated and read at the input beat. Depends on mbad_pkg.
module mbad_state import mbad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      acc_i,
  input  req_t      req_i,
  output state_rd_t st_o
);

  logic [7:0] wram [WORK_RAM_BYTES];
  logic [7:0] hram [HIGH_RAM_BYTES];

  logic [7:0] wram_rdata_q;
  logic [7:0] hram_rdata_q;
  logic [1:0] pad_select_q;
  logic [4:0] int_enable_q;
  logic       boot_mapped_q;

  logic               is_wram;
  logic               is_hram;
  logic               wr;
  logic [WRAM_AW-1:0] wram_idx;
  logic [HRAM_AW-1:0] hram_idx;

  assign is_wram  = (req_i.addr >= ADDR_WRAM) && (req_i.addr < ADDR_OAM);
  assign is_hram  = (req_i.addr >= ADDR_HRAM) && (req_i.addr != ADDR_IE);
  assign wr       = acc_i && (req_i.action == ACT_WRITE);
  assign wram_idx = req_i.addr[WRAM_AW-1:0];
  assign hram_idx = req_i.addr[HRAM_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr && is_wram) begin
      wram[wram_idx] <= req_i.wdata;
    end
    if (acc_i) begin
      wram_rdata_q <= wram[wram_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr && is_hram) begin
      hram[hram_idx] <= req_i.wdata;
    end
    if (acc_i && is_hram) begin
      hram_rdata_q <= hram[hram_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_select_q  <= 2'd0;
      int_enable_q  <= 5'd0;
      boot_mapped_q <= 1'b1;
    end else if (wr) begin
      if (req_i.addr == ADDR_JOYP) begin
        pad_select_q <= req_i.wdata[5:4];
      end
      if (req_i.addr == ADDR_IE) begin
        int_enable_q <= req_i.wdata[4:0];
      end
      if (req_i.addr == ADDR_BOOT_OFF) begin
        boot_mapped_q <= 1'b0;
      end
    end
  end

  assign st_o.wram_rdata  = wram_rdata_q;
  assign st_o.hram_rdata  = hram_rdata_q;
  assign st_o.pad_select  = pad_select_q;
  assign st_o.int_enable  = int_enable_q;
  assign st_o.boot_mapped = boot_mapped_q;

endmodule

@@ src/mbad_decode.sv @@
// Combinational decode of one registered access: target, read data merge, write forward
// and DMA request. Depends on mbad_pkg.
module mbad_decode import mbad_pkg::*; (
  input  req_t      req_i,
  input  state_rd_t st_i,
  input  logic      boot_present_i,
  output result_t   res_o
);

  tgt_e       dev;
  logic [7:0] nib;

  assign dev = device_of(req_i.addr);
  assign nib = st_i.pad_select[1] ? {4'h0, req_i.keys[3:0]} : {4'h0, req_i.keys[7:4]};

  always_comb begin
    res_o.rdata         = BYTE_OPEN;
    res_o.target        = dev;
    res_o.forward_write = 1'b0;
    res_o.dma_start     = 1'b0;
    res_o.dma_page      = 8'h00;
    if (req_i.action == ACT_READ) begin
      if (boot_present_i && st_i.boot_mapped && (req_i.addr < ADDR_BOOT_END)) begin
        res_o.rdata  = req_i.boot_rdata;
        res_o.target = TGT_NONE;
      end else begin
        case (dev)
          TGT_CART:  res_o.rdata = req_i.cart_rdata;
          TGT_VIDEO: res_o.rdata = req_i.ppu_rdata;
          TGT_SOUND: res_o.rdata = req_i.apu_rdata;
          TGT_TIMER: res_o.rdata = req_i.timer_rdata;
          TGT_VT:    res_o.rdata = IF_FILL | req_i.ppu_rdata | req_i.timer_rdata;
          default: begin
            if (req_i.addr >= ADDR_WRAM && req_i.addr < ADDR_OAM) begin
              res_o.rdata = st_i.wram_rdata;
            end else if (req_i.addr == ADDR_JOYP) begin
              res_o.rdata = JOYP_FILL | {2'b00, st_i.pad_select, 4'h0} | nib;
            end else if (req_i.addr >= ADDR_HRAM && req_i.addr != ADDR_IE) begin
              res_o.rdata = st_i.hram_rdata;
            end else if (req_i.addr == ADDR_IE) begin
              res_o.rdata = {3'b000, st_i.int_enable};
            end
          end
        endcase
      end
    end else begin
      if (dev != TGT_NONE) begin
        res_o.forward_write = 1'b1;
        if (req_i.addr == ADDR_DMA && req_i.wdata < DMA_LIMIT) begin
          res_o.dma_start = 1'b1;
          res_o.dma_page  = req_i.wdata;
        end
      end
    end
  end

endmodule

@@ src/memory_bus_address_decoder.sv @@
// Top level of the memory bus address decoder: input register, decode, result register.
// Depends on mbad_pkg, mbad_state and mbad_decode.
//
// One byte access enters per s_axis beat: tuser carries the action (0 read, 1 write),
// tdata the address, write byte, key lines and the read bytes the devices return.
// One result leaves per m_axis beat: read byte, target device, write forward flag
// and a sprite DMA request with its source page.
// One access is taken in every cycle while the receiver does not stall, the work
// RAM and high RAM read ports being read at the input beat and the decode running
// from the input register into the result register.
// When the receiver stalls, the result register holds, the input register fills
// and then s_axis_tready drops until the result is taken; nothing is lost.
// The cfg write channel sets boot_present and is always ready; write it only while
// no access is in flight.
// Reset clears both valid flags, boot_present, the joypad select and interrupt
// enable, and maps the boot ROM; RAM contents are undefined until written.
module memory_bus_address_decoder import mbad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wvalid_i,
  output logic        cfg_wready_o,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // addr, wdata, keys, cart_rdata, ppu_rdata, apu_rdata, timer_rdata, boot_rdata
  input  logic [71:0] s_axis_tdata_i,
  // action
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // rdata, target, forward_write, dma_start, dma_page, zero pad
  output logic [23:0] m_axis_tdata_o
);

  logic      boot_present_q;
  logic      s1_valid_q;
  req_t      req_q;
  req_t      req_d;
  logic      out_valid_q;
  result_t   res_q;
  result_t   res_d;
  state_rd_t st;
  logic      acc;
  logic      adv;

  assign cfg_wready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_present_q <= 1'b0;
    end else if (cfg_wvalid_i) begin
      boot_present_q <= cfg_wdata_i;
    end
  end

  assign req_d.action      = s_axis_tuser_i;
  assign req_d.addr        = s_axis_tdata_i[15:0];
  assign req_d.wdata       = s_axis_tdata_i[23:16];
  assign req_d.keys        = s_axis_tdata_i[31:24];
  assign req_d.cart_rdata  = s_axis_tdata_i[39:32];
  assign req_d.ppu_rdata   = s_axis_tdata_i[47:40];
  assign req_d.apu_rdata   = s_axis_tdata_i[55:48];
  assign req_d.timer_rdata = s_axis_tdata_i[63:56];
  assign req_d.boot_rdata  = s_axis_tdata_i[71:64];

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || adv;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_q <= req_d;
    end
    if (adv && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  mbad_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .req_i  (req_d),
    .st_o   (st)
  );

  mbad_decode u_decode (
    .req_i          (req_q),
    .st_i           (st),
    .boot_present_i (boot_present_q),
    .res_o          (res_d)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, res_q.dma_page, res_q.dma_start, res_q.forward_write,
                            res_q.target, res_q.rdata};

endmodule

@@ bench/memory_bus_address_decoder_tb.sv @@
// Self-checking bench for memory_bus_address_decoder: directed probes of the address map,
// then random accesses with random stalls on both streams, checked by an in-bench decoder.
// Depends on mbad_pkg and the decoder RTL.
module memory_bus_address_decoder_tb import mbad_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned PROBE_N     = 27;

  typedef struct packed {
    logic        act;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  keys;
    logic [7:0]  ext;
    logic [7:0]  boot;
    logic        typed;
    logic [7:0]  rdata;
    tgt_e        target;
    logic        fwd;
    logic        dma;
    logic [7:0]  page;
  } probe_t;

  localparam probe_t PROBES [PROBE_N] = '{
    '{ACT_READ,  16'h0000, 8'h00, 8'h00, 8'h3C, 8'hA5, 1'b1, 8'hA5, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'h00FF, 8'h00, 8'h00, 8'h3C, 8'h5A, 1'b1, 8'h5A, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'h0100, 8'h00, 8'h00, 8'h3C, 8'h5A, 1'b1, 8'h3C, TGT_CART,  1'b0, 1'b0, 8'h00},
    '{ACT_WRITE, 16'h0000, 8'h12, 8'h00, 8'h3C, 8'h5A, 1'b1, 8'hFF, TGT_CART,  1'b1, 1'b0, 8'h00},
    '{ACT_READ,  16'h7FFF, 8'h00, 8'h00, 8'h01, 8'h00, 1'b1, 8'h01, TGT_CART,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'h8000, 8'h00, 8'h00, 8'h80, 8'h00, 1'b1, 8'h80, TGT_VIDEO, 1'b0, 1'b0, 8'h00},
    '{ACT_WRITE, 16'hC000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_WRITE, 16'hDFFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hE000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hDFFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hFE9F, 8'h00, 8'h00, 8'h9F, 8'h00, 1'b1, 8'h9F, TGT_VIDEO, 1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hFEA0, 8'h00, 8'h00, 8'h55, 8'h00, 1'b1, 8'hFF, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_WRITE, 16'hFF00, 8'h20, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hFF00, 8'h00, 8'hA5, 8'h00, 8'h00, 1'b1, 8'hE5, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_WRITE, 16'hFF00, 8'h10, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hFF00, 8'h00, 8'hA5, 8'h00, 8'h00, 1'b1, 8'hDA, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hFF05, 8'h00, 8'h00, 8'h44, 8'h00, 1'b0, 8'h00, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hFF0F, 8'h00, 8'h00, 8'h05, 8'h00, 1'b1, 8'hE5, TGT_VT,    1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hFF26, 8'h00, 8'h00, 8'h66, 8'h00, 1'b0, 8'h00, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_WRITE, 16'hFF46, 8'hDF, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, TGT_VIDEO, 1'b1, 1'b1, 8'hDF},
    '{ACT_WRITE, 16'hFF46, 8'hE0, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, TGT_VIDEO, 1'b1, 1'b0, 8'h00},
    '{ACT_WRITE, 16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h1F, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_WRITE, 16'hFF80, 8'h77, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hFF80, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hFF01, 8'h00, 8'h00, 8'h31, 8'h00, 1'b1, 8'hFF, TGT_NONE,  1'b0, 1'b0, 8'h00},
    '{ACT_READ,  16'hFF50, 8'h00, 8'h00, 8'h31, 8'h00, 1'b1, 8'hFF, TGT_NONE,  1'b0, 1'b0, 8'h00}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_wvalid_i;
  logic        cfg_wready_o;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // addr, wdata, keys, cart_rdata, ppu_rdata, apu_rdata, timer_rdata, boot_rdata
  logic [71:0] s_axis_tdata_i;
  // action
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // rdata, target, forward_write, dma_start, dma_page, zero pad
  logic [23:0] m_axis_tdata_o;

  memory_bus_address_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wvalid_i   (cfg_wvalid_i),
    .cfg_wready_o   (cfg_wready_o),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // bench copy of the decoder state
  logic [7:0]  work_ram_model [WORK_RAM_BYTES];
  bit          work_ram_known [WORK_RAM_BYTES];
  logic [7:0]  high_ram_model [HIGH_RAM_BYTES];
  bit          high_ram_known [HIGH_RAM_BYTES];
  logic [1:0]  pad_sel;
  logic [7:0]  int_en;
  logic        boot_mapped;
  logic        boot_present;
  logic [15:0] ram_addrs_written [$];

  result_t     expected_results [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          quiet;
  bit          hold_req;
  int unsigned rx_stall;

  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = 1'b1;
      #5 clk_i = 1'b0;
    end
  end

  function automatic logic [12:0] wram_slot(input logic [15:0] a);
    logic [15:0] off;
    off = (a >= 16'hE000) ? a - 16'hE000 : a - ADDR_WRAM;
    return off[12:0];
  endfunction

  function automatic logic [6:0] hram_slot(input logic [15:0] a);
    logic [15:0] off;
    off = a - ADDR_HRAM;
    return off[6:0];
  endfunction

  function automatic result_t decode_access(input req_t r);
    result_t     res;
    tgt_e        dev;
    logic [15:0] a;
    logic [7:0]  nib;
    logic        in_wram;
    logic        in_hram;
    a = r.addr;
    in_wram = (a >= ADDR_WRAM) && (a < ADDR_OAM);
    in_hram = (a >= ADDR_HRAM) && (a < ADDR_IE);
    if (a < ADDR_VRAM || (a >= ADDR_XRAM && a < ADDR_WRAM)) begin
      dev = TGT_CART;
    end else if (a < ADDR_XRAM || (a >= ADDR_OAM && a < ADDR_OAM_END) || a == ADDR_IO_VIDEO
                 || (a > ADDR_TIMER_END - 1 && a < ADDR_IF)
                 || (a >= ADDR_SOUND_END && a < ADDR_LCD_END)) begin
      dev = TGT_VIDEO;
    end else if (a >= ADDR_TIMER && a < ADDR_TIMER_END) begin
      dev = TGT_TIMER;
    end else if (a == ADDR_IF) begin
      dev = TGT_VT;
    end else if (a >= ADDR_SOUND && a < ADDR_SOUND_END) begin
      dev = TGT_SOUND;
    end else begin
      dev = TGT_NONE;
    end
    res = '{BYTE_OPEN, dev, 1'b0, 1'b0, 8'h00};
    if (r.action == ACT_READ) begin
      if (boot_present && boot_mapped && a < ADDR_BOOT_END) begin
        res.rdata  = r.boot_rdata;
        res.target = TGT_NONE;
      end else begin
        case (dev)
          TGT_CART:  res.rdata = r.cart_rdata;
          TGT_VIDEO: res.rdata = r.ppu_rdata;
          TGT_SOUND: res.rdata = r.apu_rdata;
          TGT_TIMER: res.rdata = r.timer_rdata;
          TGT_VT:    res.rdata = IF_FILL | r.ppu_rdata | r.timer_rdata;
          default: begin
            if (in_wram) begin
              res.rdata = work_ram_model[wram_slot(a)];
            end else if (a == ADDR_JOYP) begin
              nib = pad_sel[1] ? {4'h0, r.keys[3:0]} : {4'h0, r.keys[7:4]};
              res.rdata = JOYP_FILL | {2'b00, pad_sel, 4'h0} | nib;
            end else if (in_hram) begin
              res.rdata = high_ram_model[hram_slot(a)];
            end else if (a == ADDR_IE) begin
              res.rdata = int_en;
            end
          end
        endcase
      end
    end else if (dev != TGT_NONE) begin
      res.forward_write = 1'b1;
      if (a == ADDR_DMA && r.wdata < DMA_LIMIT) begin
        res.dma_start = 1'b1;
        res.dma_page  = r.wdata;
      end
    end else if (in_wram) begin
      work_ram_model[wram_slot(a)] = r.wdata;
      work_ram_known[wram_slot(a)] = 1'b1;
      ram_addrs_written.push_back(a);
    end else if (a == ADDR_JOYP) begin
      pad_sel = r.wdata[5:4];
    end else if (a == ADDR_BOOT_OFF) begin
      boot_mapped = 1'b0;
    end else if (in_hram) begin
      high_ram_model[hram_slot(a)] = r.wdata;
      high_ram_known[hram_slot(a)] = 1'b1;
      ram_addrs_written.push_back(a);
    end else if (a == ADDR_IE) begin
      int_en[4:0] = r.wdata[4:0];
    end
    if (ram_addrs_written.size() > 32) begin
      void'(ram_addrs_written.pop_front());
    end
    return res;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_access(input req_t r, input bit typed, input result_t want);
    result_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= r.action;
    s_axis_tdata_i  <= {r.boot_rdata, r.timer_rdata, r.apu_rdata, r.ppu_rdata,
                        r.cart_rdata, r.keys, r.wdata, r.addr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = decode_access(r);
    expected_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic random_access(input bit allow_unmap);
    req_t        r;
    int unsigned kind;
    r.action      = 1'($urandom_range(0, 1));
    r.wdata       = 8'($urandom_range(0, 255));
    r.keys        = 8'($urandom_range(0, 255));
    r.cart_rdata  = 8'($urandom_range(0, 255));
    r.ppu_rdata   = 8'($urandom_range(0, 255));
    r.apu_rdata   = 8'($urandom_range(0, 255));
    r.timer_rdata = 8'($urandom_range(0, 255));
    r.boot_rdata  = 8'($urandom_range(0, 255));
    kind = $urandom_range(0, 15);
    case (kind)
      0, 1:    r.addr = 16'($urandom_range(0, 16'h01FF));
      2, 3:    r.addr = 16'($urandom_range(0, 16'hFFFF));
      4, 5, 6: r.addr = 16'($urandom_range(ADDR_WRAM, ADDR_OAM - 1));
      7, 8:    r.addr = 16'($urandom_range(ADDR_JOYP, ADDR_HRAM - 1));
      9, 10:   r.addr = 16'($urandom_range(ADDR_HRAM, ADDR_IE));
      11:      r.addr = ADDR_DMA;
      12:      r.addr = ADDR_JOYP;
      13:      r.addr = 16'($urandom_range(ADDR_OAM, ADDR_JOYP - 1));
      default: begin
        if (ram_addrs_written.size() != 0) begin
          r.addr   = ram_addrs_written[$urandom_range(0, ram_addrs_written.size() - 1)];
          r.action = ACT_READ;
        end else begin
          r.addr = 16'($urandom_range(ADDR_WRAM, ADDR_OAM - 1));
        end
      end
    endcase
    // never read a ram cell that has not been written yet
    if (r.action == ACT_READ) begin
      if (r.addr >= ADDR_WRAM && r.addr < ADDR_OAM && !work_ram_known[wram_slot(r.addr)]) begin
        r.action = ACT_WRITE;
      end else if (r.addr >= ADDR_HRAM && r.addr < ADDR_IE
                   && !high_ram_known[hram_slot(r.addr)]) begin
        r.action = ACT_WRITE;
      end
    end
    if (r.action == ACT_WRITE && r.addr == ADDR_BOOT_OFF && !allow_unmap) begin
      r.action = ACT_READ;
    end
    send_access(r, 1'b0, '0);
  endtask

  task automatic set_boot_present(input logic v);
    cfg_wvalid_i <= 1'b1;
    cfg_wdata_i  <= v;
    do @(posedge clk_i); while (!cfg_wready_o);
    boot_present = v;
    @(negedge clk_i);
    cfg_wvalid_i <= 1'b0;
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // receiver: random stall bursts plus one long hold-off
  initial begin
    m_axis_tready_i = 1'b0;
    rx_stall        = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (rx_stall > 0) begin
        m_axis_tready_i <= 1'b0;
        rx_stall--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(1, 13) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no access pending: %h", m_axis_tdata_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata_o[7:0] !== want.rdata) begin
          $error("rdata expected %h got %h", want.rdata, m_axis_tdata_o[7:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[10:8] !== want.target) begin
          $error("target expected %0d got %0d", want.target, m_axis_tdata_o[10:8]);
          mismatches++;
        end
        if (m_axis_tdata_o[11] !== want.forward_write) begin
          $error("forward_write expected %b got %b", want.forward_write, m_axis_tdata_o[11]);
          mismatches++;
        end
        if (m_axis_tdata_o[12] !== want.dma_start) begin
          $error("dma_start expected %b got %b", want.dma_start, m_axis_tdata_o[12]);
          mismatches++;
        end
        if (m_axis_tdata_o[20:13] !== want.dma_page) begin
          $error("dma_page expected %h got %h", want.dma_page, m_axis_tdata_o[20:13]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    probe_t p;
    req_t   r;
    int     phase_len [4];
    rst_ni          = 1'b0;
    cfg_wvalid_i    = 1'b0;
    cfg_wdata_i     = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tdata_i  = '0;
    mismatches      = 0;
    cycle_count     = 0;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    pad_sel         = '0;
    int_en          = '0;
    boot_mapped     = 1'b1;
    boot_present    = 1'b0;
    phase_len       = '{550, 550, 450, 400};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_boot_present(1'b1);
    for (int i = 0; i < PROBE_N; i++) begin
      p = PROBES[i];
      r = '{p.act, p.addr, p.wdata, p.keys, p.ext, p.ext, p.ext, p.ext, p.boot};
      send_access(r, p.typed, '{p.rdata, p.target, p.fwd, p.dma, p.page});
    end

    // boot overlay off, on, off, then on with boot unmap writes allowed
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      set_boot_present(ph[0]);
      for (int i = 0; i < phase_len[ph]; i++) begin
        if (ph == 1 && i == 200) begin
          hold_req = 1'b1;
        end
        if (ph == 3 && i == phase_len[ph] - 200) begin
          quiet = 1'b1;
        end
        random_access(ph == 3);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/mbad_pkg.sv
src/mbad_state.sv
src/mbad_decode.sv
src/memory_bus_address_decoder.sv
bench/memory_bus_address_decoder_tb.sv
